@@ rtl/websocket_frame_deframer_top_assert.svh @@
// assertion macros for the websocket deframer top level
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wsfd_pkg.sv @@
`default_nettype none

package wsfd_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_CTRL  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] frame_opcode;
    logic       fin_bit;
    kind_t      result_kind;
    logic       empty_frame;
    logic       last_of_frame;
  } res_t;

  // result beat leaving the parser
  typedef struct packed {
    logic vld;
    res_t res;
  } res_beat_t;

  // output queue status
  typedef struct packed {
    logic full;
  } fifo_sts_t;

  // kind of a frame from its header byte
  function automatic kind_t frame_kind(input logic [7:0] hdr);
    kind_t k;
    if (!hdr[3]) begin
      k = KIND_DATA;
    end else if (hdr[3:0] == OP_PING) begin
      k = KIND_PING;
    end else if (hdr[3:0] == OP_CLOSE) begin
      k = KIND_CLOSE;
    end else begin
      k = KIND_CTRL;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/wsfd_parser.sv @@
`default_nettype none

module wsfd_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wsfd_pkg::fifo_sts_t        sts,
  output wsfd_pkg::res_beat_t        beat
);
  import wsfd_pkg::*;

  logic [7:0]  byte_r;
  logic        byte_vld_r, byte_vld_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic        masked_r, masked_nxt;
  logic [2:0]  ext_cnt_r, ext_cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic        closed_r, closed_nxt;

  logic        consume, go, in_acc;
  logic [6:0]  len7;
  logic        len_is_ext, len_done, hdr_done, masked_now;
  logic [63:0] rem_hd, rem_dec;
  logic        rem_zero, pay_last;
  kind_t       kind;
  logic [7:0]  kb;
  logic        emit_empty, emit_pay;

  // input register handshake
  assign consume  = byte_vld_r && !sts.full;
  assign in_stall = byte_vld_r && sts.full;
  assign in_acc   = in_valid && !in_stall;
  assign go       = consume && !closed_r;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_acc) begin
      byte_vld_nxt = 1'b1;
    end else if (consume) begin
      byte_vld_nxt = 1'b0;
    end
  end

  // decode of the byte against the current phase
  assign len7       = byte_r[6:0];
  assign len_is_ext = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
  assign masked_now = (phase_r == PH_LEN) ? byte_r[7] : masked_r;
  assign kind       = frame_kind(hdr_r);
  assign rem_dec    = rem_r - 64'd1;
  assign pay_last   = (rem_dec == 64'd0);

  always_comb begin
    case (phase_r)
      PH_LEN:    rem_hd = {57'd0, len7};
      PH_EXTLEN: rem_hd = {rem_r[55:0], byte_r};
      default:   rem_hd = rem_r;
    endcase
  end

  assign rem_zero = (rem_hd == 64'd0);
  assign len_done = ((phase_r == PH_LEN) && !len_is_ext) ||
                    ((phase_r == PH_EXTLEN) && (ext_cnt_r == 3'd0));
  assign hdr_done = (len_done && !masked_now) ||
                    ((phase_r == PH_KEY) && (kidx_r == 2'd3));

  // key byte for the payload position, first key byte received first
  always_comb begin
    case (kidx_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      unique case (phase_r)
        PH_LEN, PH_EXTLEN: begin
          if (len_done) begin
            if (masked_now) begin
              phase_nxt = PH_KEY;
            end else begin
              phase_nxt = rem_zero ? PH_HEADER : PH_PAYLOAD;
            end
          end else begin
            phase_nxt = PH_EXTLEN;
          end
        end
        PH_KEY: begin
          if (hdr_done) begin
            phase_nxt = rem_zero ? PH_HEADER : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  // frame state updates
  always_comb begin
    hdr_nxt     = hdr_r;
    masked_nxt  = masked_r;
    ext_cnt_nxt = ext_cnt_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    kidx_nxt    = kidx_r;
    if (go) begin
      unique case (phase_r)
        PH_LEN: begin
          masked_nxt = byte_r[7];
          if (len_is_ext) begin
            rem_nxt     = 64'd0;
            ext_cnt_nxt = (len7 == LEN_EXT64) ? EXT64_CNT : EXT16_CNT;
          end else begin
            rem_nxt  = rem_hd;
            kidx_nxt = 2'd0;
          end
        end
        PH_EXTLEN: begin
          rem_nxt = rem_hd;
          if (len_done) begin
            kidx_nxt = 2'd0;
          end else begin
            ext_cnt_nxt = ext_cnt_r - 3'd1;
          end
        end
        PH_KEY: begin
          key_nxt  = {key_r[23:0], byte_r};
          kidx_nxt = kidx_r + 2'd1;
        end
        PH_PAYLOAD: begin
          rem_nxt  = rem_dec;
          kidx_nxt = kidx_r + 2'd1;
        end
        default: begin
          hdr_nxt     = byte_r;
          masked_nxt  = 1'b0;
          ext_cnt_nxt = 3'd0;
          rem_nxt     = 64'd0;
          key_nxt     = 32'd0;
          kidx_nxt    = 2'd0;
        end
      endcase
    end
  end

  // result beat
  assign emit_empty = hdr_done && rem_zero;
  assign emit_pay   = (phase_r == PH_PAYLOAD) && ((kind != KIND_CLOSE) || pay_last);

  always_comb begin
    beat.vld               = go && (emit_empty || emit_pay);
    beat.res.frame_opcode  = hdr_r[3:0];
    beat.res.fin_bit       = hdr_r[7];
    beat.res.result_kind   = kind;
    beat.res.empty_frame   = emit_empty;
    beat.res.last_of_frame = emit_empty || pay_last;
    if (emit_empty || (kind == KIND_CLOSE)) begin
      beat.res.out_byte = 8'd0;
    end else begin
      beat.res.out_byte = byte_r ^ kb;
    end
  end

  assign closed_nxt = closed_r || (beat.vld && (kind == KIND_CLOSE));

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      phase_r    <= PH_HEADER;
      hdr_r      <= 8'd0;
      masked_r   <= 1'b0;
      ext_cnt_r  <= 3'd0;
      rem_r      <= 64'd0;
      key_r      <= 32'd0;
      kidx_r     <= 2'd0;
      closed_r   <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      phase_r    <= phase_nxt;
      hdr_r      <= hdr_nxt;
      masked_r   <= masked_nxt;
      ext_cnt_r  <= ext_cnt_nxt;
      rem_r      <= rem_nxt;
      key_r      <= key_nxt;
      kidx_r     <= kidx_nxt;
      closed_r   <= closed_nxt;
    end
  end

  // byte holding register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_data_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsfd_out_fifo.sv @@
`default_nettype none

module wsfd_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wsfd_pkg::res_beat_t       beat,
  output wsfd_pkg::fifo_sts_t       sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wsfd_pkg::res_t            head
);
  import wsfd_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push      = beat.vld;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = slot_r[rd_ptr_r];
  assign sts.full  = (cnt_r == 2'd2);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= beat.res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer_top.sv @@
// websocket frame deframer, one stream byte per beat
// an accepted byte is held in the parser byte register, and its result beat is registered in the result queue
// throughput: one byte per cycle while the result queue is not full, set by the frame parser stage
// a two-entry result queue lets bytes keep flowing while a result waits
// reset: synchronous active-low rst_n returns the parser to header and reopens it
`default_nettype none
`include "websocket_frame_deframer_top_assert.svh"

module websocket_frame_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_out_byte,
  output logic [3:0]       out_frame_opcode,
  output logic             out_fin_bit,
  output logic [1:0]       out_result_kind,
  output logic             out_empty_frame,
  output logic             out_last_of_frame
);
  import wsfd_pkg::*;

  res_beat_t beat;
  fifo_sts_t sts;
  res_t      head;

  // parser stage
  wsfd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .sts          (sts),
    .beat         (beat)
  );

  // result queue
  wsfd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // result fields
  assign out_out_byte      = head.out_byte;
  assign out_frame_opcode  = head.frame_opcode;
  assign out_fin_bit       = head.fin_bit;
  assign out_result_kind   = head.result_kind;
  assign out_empty_frame   = head.empty_frame;
  assign out_last_of_frame = head.last_of_frame;

  // checks
  `WSFD_ASSERT_NEXT(a_close_silences, beat.vld && (beat.res.result_kind == KIND_CLOSE), !beat.vld, "result after close event")
  `WSFD_ASSERT_NOW(a_no_push_full, beat.vld, !sts.full, "result pushed into full queue")
  `WSFD_ASSERT_NOW(a_stall_only_full, in_stall, sts.full, "input stalled with queue room")
  `WSFD_ASSERT_NOW(a_empty_is_last, out_valid && out_empty_frame, out_last_of_frame && (out_out_byte == 8'd0), "empty frame result malformed")

endmodule

`default_nettype wire

@@ dv/websocket_frame_deframer_top_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top_tb;
  import wsfd_pkg::*;

  localparam int ITEMS = 700;

  // length encodings used when building frames
  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_out_byte;
  logic [3:0] out_frame_opcode;
  logic       out_fin_bit;
  logic [1:0] out_result_kind;
  logic       out_empty_frame;
  logic       out_last_of_frame;

  websocket_frame_deframer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_byte     (out_out_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_fin_bit      (out_fin_bit),
    .out_result_kind  (out_result_kind),
    .out_empty_frame  (out_empty_frame),
    .out_last_of_frame(out_last_of_frame)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // stream bytes waiting to be sent and beats waiting to arrive
  logic [7:0] tx_bytes[$];
  res_t       expected_beats[$];
  int         errors = 0;

  // parser state mirrored by the predictor
  phase_t      psr_phase  = PH_HEADER;
  logic [7:0]  psr_hdr    = 8'h00;
  logic        psr_masked = 1'b0;
  logic [2:0]  psr_extcnt = 3'd0;
  logic [63:0] psr_remain = 64'd0;
  logic [31:0] psr_key    = 32'd0;
  logic [1:0]  psr_kidx   = 2'd0;
  logic        psr_closed = 1'b0;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // result beat tagged with the current header
  function automatic res_t mk_beat(input logic [7:0] val, input kind_t k,
                                   input logic empty, input logic last);
    res_t r;
    r.out_byte      = val;
    r.frame_opcode  = psr_hdr[3:0];
    r.fin_bit       = psr_hdr[7];
    r.result_kind   = k;
    r.empty_frame   = empty;
    r.last_of_frame = last;
    return r;
  endfunction

  // advance the frame parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    kind_t      k;
    logic       len_done;
    logic       hdr_done;
    logic [7:0] kb;
    len_done = 1'b0;
    hdr_done = 1'b0;
    if (!psr_hdr[3]) begin
      k = KIND_DATA;
    end else if (psr_hdr[3:0] == OP_PING) begin
      k = KIND_PING;
    end else if (psr_hdr[3:0] == OP_CLOSE) begin
      k = KIND_CLOSE;
    end else begin
      k = KIND_CTRL;
    end
    if (!psr_closed) begin
      case (psr_phase)
        PH_LEN: begin
          psr_masked = b[7];
          psr_remain = 64'd0;
          if (b[6:0] == LEN_EXT16) begin
            psr_extcnt = EXT16_CNT;
            psr_phase  = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            psr_extcnt = EXT64_CNT;
            psr_phase  = PH_EXTLEN;
          end else begin
            psr_remain = {57'd0, b[6:0]};
            len_done   = 1'b1;
          end
        end
        PH_EXTLEN: begin
          psr_remain = {psr_remain[55:0], b};
          if (psr_extcnt == 3'd0) len_done = 1'b1;
          else psr_extcnt = psr_extcnt - 3'd1;
        end
        PH_KEY: begin
          psr_key = {psr_key[23:0], b};
          if (psr_kidx == 2'd3) hdr_done = 1'b1;
          else psr_kidx = psr_kidx + 2'd1;
        end
        PH_PAYLOAD: begin
          kb = psr_key[8 * (3 - psr_kidx) +: 8];
          psr_kidx   = psr_kidx + 2'd1;
          psr_remain = psr_remain - 64'd1;
          if (psr_remain == 64'd0) psr_phase = PH_HEADER;
          // close payload is swallowed, one event at its end
          if (k == KIND_CLOSE) begin
            if (psr_remain == 64'd0) begin
              expected_beats.push_back(mk_beat(8'h00, KIND_CLOSE, 1'b0, 1'b1));
              psr_closed = 1'b1;
            end
          end else begin
            expected_beats.push_back(mk_beat(b ^ kb, k, 1'b0, psr_remain == 64'd0));
          end
        end
        default: begin
          psr_hdr    = b;
          psr_masked = 1'b0;
          psr_extcnt = 3'd0;
          psr_remain = 64'd0;
          psr_key    = 32'd0;
          psr_kidx   = 2'd0;
          psr_phase  = PH_LEN;
        end
      endcase
      // length complete: go for the key or finish the header
      if (len_done) begin
        if (psr_masked) begin
          psr_phase = PH_KEY;
          psr_kidx  = 2'd0;
        end else begin
          hdr_done = 1'b1;
        end
      end
      // header complete: payload follows or the frame is empty
      if (hdr_done) begin
        psr_kidx = 2'd0;
        if (psr_remain != 64'd0) begin
          psr_phase = PH_PAYLOAD;
        end else begin
          psr_phase = PH_HEADER;
          expected_beats.push_back(mk_beat(8'h00, k, 1'b1, 1'b1));
          if (k == KIND_CLOSE) psr_closed = 1'b1;
        end
      end
    end
  endtask

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // append one frame; body is how many payload bytes actually follow
  task automatic push_frame(input logic [7:0] hdr, input logic masked,
                            input len_form_t form, input logic [63:0] len,
                            input int body);
    tx_bytes.push_back(hdr);
    case (form)
      FORM_EXT16: begin
        tx_bytes.push_back({masked, LEN_EXT16});
        tx_bytes.push_back(len[15:8]);
        tx_bytes.push_back(len[7:0]);
      end
      FORM_EXT64: begin
        tx_bytes.push_back({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) tx_bytes.push_back(len[8 * i +: 8]);
      end
      default: tx_bytes.push_back({masked, len[6:0]});
    endcase
    if (masked) repeat (4) tx_bytes.push_back(8'($urandom_range(0, 255)));
    repeat (body) tx_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // random header that is not a close frame
  function automatic logic [7:0] open_hdr();
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    while (h[3] && h[3:0] == OP_CLOSE) h = 8'($urandom_range(0, 255));
    return h;
  endfunction

  // stimulus
  initial begin
    int          p;
    int          n;
    logic [63:0] len;
    logic [7:0]  h;
    // directed: extreme payload bytes, unmasked and through an all-ones key byte
    tx_bytes = {tx_bytes, 8'h81, 8'h02, 8'h00, 8'hff};
    tx_bytes = {tx_bytes, 8'h02, 8'h82, 8'hff, 8'h00, 8'ha5, 8'h3c, 8'hff, 8'h00};
    // directed: empty data, empty masked ping, ping and other control payloads
    push_frame(8'h80, 1'b0, FORM_SHORT, 64'd0, 0);
    push_frame(8'h89, 1'b1, FORM_SHORT, 64'd0, 0);
    push_frame(8'h09, 1'b1, FORM_SHORT, 64'd2, 2);
    push_frame(8'hfa, 1'b0, FORM_SHORT, 64'd1, 1);
    // directed: extended lengths, zero and values that fit the short form
    push_frame(8'h82, 1'b0, FORM_EXT16, 64'd0, 0);
    push_frame(8'h70, 1'b1, FORM_EXT16, 64'd2, 2);
    push_frame(8'h8f, 1'b0, FORM_EXT64, 64'd1, 1);
    push_frame(8'h8b, 1'b1, FORM_EXT64, 64'd0, 0);
    // random well-formed frames, mostly short
    while (tx_bytes.size() < ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 65) begin
        n = $urandom_range(0, 8);
        push_frame(open_hdr(), 1'($urandom_range(0, 1)), FORM_SHORT, 64'(n), n);
      end else if (p < 72) begin
        n = $urandom_range(9, 125);
        push_frame(open_hdr(), 1'($urandom_range(0, 1)), FORM_SHORT, 64'(n), n);
      end else if (p < 87) begin
        n = $urandom_range(0, 20);
        push_frame(open_hdr(), 1'($urandom_range(0, 1)), FORM_EXT16, 64'(n), n);
      end else if (p < 89) begin
        n = $urandom_range(256, 300);
        push_frame(open_hdr(), 1'($urandom_range(0, 1)), FORM_EXT16, 64'(n), n);
      end else if (p < 98) begin
        n = $urandom_range(0, 12);
        push_frame(open_hdr(), 1'($urandom_range(0, 1)), FORM_EXT64, 64'(n), n);
      end else begin
        n = $urandom_range(256, 280);
        push_frame(open_hdr(), 1'($urandom_range(0, 1)), FORM_EXT64, 64'(n), n);
      end
    end
    // closing frame, or a frame whose length has the top bit set
    h = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), OP_CLOSE};
    case ($urandom_range(0, 2))
      0: push_frame(h, 1'($urandom_range(0, 1)), FORM_SHORT, 64'd0, 0);
      1: begin
        n = $urandom_range(1, 6);
        push_frame(h, 1'($urandom_range(0, 1)), FORM_SHORT, 64'(n), n);
      end
      default: begin
        len = {$urandom | 32'h8000_0000, $urandom};
        push_frame(open_hdr(), 1'($urandom_range(0, 1)), FORM_EXT64, len, 20);
      end
    endcase
    // trailing bytes, dropped once closed
    repeat (10) tx_bytes.push_back(8'($urandom_range(0, 255)));
  end

  // reset
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: hold each byte until accepted, idle between beats at random
  int   in_gap = 0;
  logic in_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_data_byte);
      if ($urandom_range(0, 39) == 0) in_calm <= !in_calm;
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (tx_bytes.size() > 0) begin
          in_valid     <= 1'b1;
          in_data_byte <= tx_bytes.pop_front();
          in_gap       <= in_calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted result beat, stall at random
  int   out_hold = 0;
  logic out_calm = 1'b0;
  always @(posedge clk) begin : monitor_proc
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          flag_error($sformatf("unexpected beat, byte %02h kind %0d",
                               out_out_byte, out_result_kind));
        end else begin
          want = expected_beats.pop_front();
          if (out_out_byte !== want.out_byte)
            flag_error($sformatf("out_byte %02h, want %02h", out_out_byte, want.out_byte));
          if (out_frame_opcode !== want.frame_opcode)
            flag_error($sformatf("frame_opcode %0h, want %0h",
                                 out_frame_opcode, want.frame_opcode));
          if (out_fin_bit !== want.fin_bit)
            flag_error($sformatf("fin_bit %0b, want %0b", out_fin_bit, want.fin_bit));
          if (out_result_kind !== want.result_kind)
            flag_error($sformatf("result_kind %0d, want %0d",
                                 out_result_kind, want.result_kind));
          if (out_empty_frame !== want.empty_frame)
            flag_error($sformatf("empty_frame %0b, want %0b",
                                 out_empty_frame, want.empty_frame));
          if (out_last_of_frame !== want.last_of_frame)
            flag_error($sformatf("last_of_frame %0b, want %0b",
                                 out_last_of_frame, want.last_of_frame));
        end
      end
      if ($urandom_range(0, 39) == 0) out_calm <= !out_calm;
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold  <= out_hold - 1;
      end else begin
        out_stall <= 1'b0;
        if (!out_calm && $urandom_range(0, 3) == 0) out_hold <= pick_gap();
      end
    end
  end

  // end of run: all bytes sent, all beats in, then drain a little
  initial begin
    @(posedge rst_n);
    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("websocket_frame_deframer_top_tb OK");
    end else begin
      $display("websocket_frame_deframer_top_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("ERROR: timeout, %0d beats still expected", expected_beats.size());
    $display("websocket_frame_deframer_top_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

@@ websocket_frame_deframer_top.f @@
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_fifo.sv
rtl/websocket_frame_deframer_top.sv
dv/websocket_frame_deframer_top_tb.sv
